// File: rtl/assert_macros.svh
// Assertion macros shared by the frame buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/lmfb_pkg.sv
// Types, request codes and helpers for the LED matrix frame buffer.
package lmfb_pkg;

	localparam logic [3:0] REQ_SET       = 4'd0;
	localparam logic [3:0] REQ_TOGGLE    = 4'd1;
	localparam logic [3:0] REQ_ROW       = 4'd2;
	localparam logic [3:0] REQ_COL       = 4'd3;
	localparam logic [3:0] REQ_HSPAN     = 4'd4;
	localparam logic [3:0] REQ_VSPAN     = 4'd5;
	localparam logic [3:0] REQ_REFRESH   = 4'd6;
	localparam logic [3:0] REQ_CLEAR     = 4'd7;
	localparam logic [3:0] REQ_INTENSITY = 4'd8;

	localparam logic [3:0] INTENSITY_ADDR = 4'd10;
	localparam logic [3:0] INTENSITY_MAX  = 4'd15;

	// Word index of the mirror register (paddr[2]).
	localparam logic CFG_MIRROR_IDX = 1'b0;

	typedef struct packed {
		logic [3:0]        req_type;
		logic [3:0]        col_index;
		logic [3:0]        row_index;
		logic              pixel_on;
		logic [7:0]        row_bits;
		logic [3:0]        span_start;
		logic [3:0]        span_end;
		logic signed [7:0] brightness;
	} lmfb_req_t;

	typedef struct packed {
		logic [3:0] reg_address;
		logic [7:0] reg_data;
		logic       last_write;
	} lmfb_wr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN
	} lmfb_state_t;

	typedef struct packed {
		logic capture;
		logic draw;
		logic clear_frame;
		logic emit_int;
		logic emit_row;
	} lmfb_cmd_t;

	typedef struct packed {
		logic [3:0] req_type;
		logic       dirty_any;
		logic       dirty_last;
		logic       out_free;
	} lmfb_sts_t;

	// Bit of the row byte that holds column x.
	function automatic logic [7:0] col_bit(input logic [2:0] x, input logic mirror);
		col_bit = mirror ? (8'd1 << x) : (8'd128 >> x);
	endfunction

endpackage

// File: rtl/lmfb_regs.sv
// APB configuration register file: column mirror bit.
module lmfb_regs (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic        mirror
);
	import lmfb_pkg::*;

	logic mirror_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mirror_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2] == CFG_MIRROR_IDX) begin
			mirror_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == CFG_MIRROR_IDX) ? {31'd0, mirror_q} : 32'd0;
	assign pready = 1'b1;
	assign mirror = mirror_q;

endmodule

// File: rtl/lmfb_ctrl.sv
// Request sequencer: accepts a request, runs its drawing, scan or intensity step.
module lmfb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output lmfb_pkg::lmfb_cmd_t cmd,
	input  lmfb_pkg::lmfb_sts_t sts
);
	import lmfb_pkg::*;

	lmfb_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				unique case (sts.req_type)
					REQ_REFRESH, REQ_CLEAR: state_d = ST_SCAN;
					REQ_INTENSITY: state_d = sts.out_free ? ST_IDLE : ST_EXEC;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_SCAN: begin
				if (!sts.dirty_any || (sts.out_free && sts.dirty_last)) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			ST_EXEC: begin
				unique case (sts.req_type)
					REQ_SET, REQ_TOGGLE, REQ_ROW, REQ_COL, REQ_HSPAN, REQ_VSPAN:
						cmd.draw = 1'b1;
					REQ_CLEAR: cmd.clear_frame = 1'b1;
					REQ_INTENSITY: cmd.emit_int = sts.out_free;
					default: ;
				endcase
			end
			ST_SCAN: begin
				cmd.emit_row = sts.dirty_any && sts.out_free;
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/lmfb_dp.sv
// Datapath: request register, frame rows, dirty mask and output word register.
`include "assert_macros.svh"

module lmfb_dp #(
	parameter int COLS = 8,
	parameter int ROWS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                mirror,
	input  lmfb_pkg::lmfb_cmd_t cmd,
	input  lmfb_pkg::lmfb_req_t req,
	output lmfb_pkg::lmfb_sts_t sts,
	output logic                wr_valid,
	input  logic                wr_ready,
	output lmfb_pkg::lmfb_wr_t  wr_word
);
	import lmfb_pkg::*;

	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

	lmfb_req_t      req_q;
	logic [7:0]     frame_q [ROWS];
	logic [ROWS-1:0] dirty_q;
	lmfb_wr_t       wr_q;
	logic           wr_valid_q;

	logic [7:0]     pix_mask;
	logic [7:0]     hspan_mask;
	logic           col_ok;
	logic           row_ok;
	logic [7:0]     row_next [ROWS];
	logic [ROWS-1:0] row_hit;
	logic [RW-1:0]  row_sel;
	logic           dirty_last;
	logic           out_free;
	logic [3:0]     level;

	always_ff @(posedge clk) begin
		if (cmd.capture) req_q <= req;
	end

	assign col_ok   = req_q.col_index < 4'(COLS);
	assign row_ok   = req_q.row_index < 4'(ROWS);
	assign pix_mask = col_bit(req_q.col_index[2:0], mirror);

	// Columns of a horizontal span that fall inside the matrix.
	always_comb begin
		hspan_mask = 8'd0;
		for (int x = 0; x < COLS; x++) begin
			if (4'(x) >= req_q.span_start && 4'(x) < req_q.span_end)
				hspan_mask = hspan_mask | col_bit(3'(x), mirror);
		end
	end

	// Next value of each row for the pending drawing request.
	always_comb begin
		for (int y = 0; y < ROWS; y++) begin
			row_hit[y]  = 1'b0;
			row_next[y] = frame_q[y];
			unique case (req_q.req_type)
				REQ_SET: begin
					row_hit[y]  = col_ok && row_ok && req_q.row_index == 4'(y);
					row_next[y] = req_q.pixel_on ? (frame_q[y] | pix_mask)
					                             : (frame_q[y] & ~pix_mask);
				end
				REQ_TOGGLE: begin
					row_hit[y]  = col_ok && row_ok && req_q.row_index == 4'(y);
					row_next[y] = frame_q[y] ^ pix_mask;
				end
				REQ_ROW: begin
					row_hit[y]  = row_ok && req_q.row_index == 4'(y);
					row_next[y] = req_q.row_bits;
				end
				REQ_COL: begin
					row_hit[y]  = col_ok;
					row_next[y] = req_q.pixel_on ? (frame_q[y] | pix_mask)
					                             : (frame_q[y] & ~pix_mask);
				end
				REQ_HSPAN: begin
					row_hit[y]  = req_q.row_index == 4'(y) && hspan_mask != 8'd0;
					row_next[y] = req_q.pixel_on ? (frame_q[y] | hspan_mask)
					                             : (frame_q[y] & ~hspan_mask);
				end
				REQ_VSPAN: begin
					row_hit[y]  = col_ok && 4'(y) >= req_q.span_start
					              && 4'(y) < req_q.span_end;
					row_next[y] = req_q.pixel_on ? (frame_q[y] | pix_mask)
					                             : (frame_q[y] & ~pix_mask);
				end
				default: ;
			endcase
		end
	end

	// Lowest dirty row goes out first.
	always_comb begin
		row_sel = '0;
		for (int y = ROWS - 1; y >= 0; y--) begin
			if (dirty_q[y]) row_sel = RW'(y);
		end
	end

	assign dirty_last = (dirty_q & (dirty_q - ROWS'(1))) == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int y = 0; y < ROWS; y++) frame_q[y] <= 8'd0;
			dirty_q <= '1;
		end else if (cmd.clear_frame) begin
			for (int y = 0; y < ROWS; y++) frame_q[y] <= 8'd0;
			dirty_q <= '1;
		end else if (cmd.draw) begin
			for (int y = 0; y < ROWS; y++) begin
				if (row_hit[y]) begin
					frame_q[y] <= row_next[y];
					dirty_q[y] <= 1'b1;
				end
			end
		end else if (cmd.emit_row) begin
			dirty_q[row_sel] <= 1'b0;
		end
	end

	// Clamp the signed intensity to 0..15.
	always_comb begin
		if (req_q.brightness[7])
			level = 4'd0;
		else if (req_q.brightness[6:4] != 3'd0)
			level = INTENSITY_MAX;
		else
			level = req_q.brightness[3:0];
	end

	assign out_free = !wr_valid_q || wr_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
		end else if (cmd.emit_int || cmd.emit_row) begin
			wr_valid_q <= 1'b1;
		end else if (wr_ready) begin
			wr_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_int) begin
			wr_q <= '{reg_address: INTENSITY_ADDR, reg_data: {4'd0, level},
			          last_write: 1'b1};
		end else if (cmd.emit_row) begin
			wr_q <= '{reg_address: 4'(row_sel) + 4'd1, reg_data: frame_q[row_sel],
			          last_write: dirty_last};
		end
	end

	assign sts.req_type   = req_q.req_type;
	assign sts.dirty_any  = |dirty_q;
	assign sts.dirty_last = dirty_last;
	assign sts.out_free   = out_free;

	assign wr_valid = wr_valid_q;
	assign wr_word  = wr_q;

	`ASSERT_HOLDS(a_emit_needs_dirty, clk, arst_n, !cmd.emit_row || (|dirty_q), "row write with no dirty row")
	`ASSERT_HOLDS(a_no_overwrite, clk, arst_n, !(cmd.emit_row || cmd.emit_int) || out_free, "output word overwritten")
	`ASSERT_NEXT(a_dirty_drops, clk, arst_n, cmd.emit_row, !dirty_q[$past(row_sel)], "written row still dirty")

endmodule

// File: rtl/led_matrix_frame_buffer.sv
// Frame buffer for a one-bit LED matrix of up to 8x8 pixels. Drawing requests (set,
// toggle, row write, column, horizontal and vertical span) update the buffer and mark
// the rows they touch dirty; they produce no output word. A refresh sends one display
// register write (address row+1, row byte) per dirty row, lowest row first, with
// last_write on the final one, then the mask is empty; a clear zeroes the buffer and
// refreshes all rows. An intensity request sends one write to register 10 with the
// value clamped to 0..15. An accepted request is registered, then applied in the
// execute state, where an intensity request waits while the output register is full;
// a refresh or clear then goes on to the row scan, which emits one word per cycle
// from the dirty-mask priority pick and stalls while the output register is full.
// A new request is taken as soon as the sequencer is idle, even while the last word
// waits on the output. Register 0 (byte address 0) holds the column mirror bit.
module led_matrix_frame_buffer #(
	parameter int MATRIX_COLS = 8,
	parameter int MATRIX_ROWS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  lmfb_pkg::lmfb_req_t req_word,
	output logic                wr_valid,
	input  logic                wr_ready,
	output lmfb_pkg::lmfb_wr_t  wr_word,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import lmfb_pkg::*;

	logic      mirror;
	lmfb_cmd_t cmd;
	lmfb_sts_t sts;

	lmfb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.mirror  (mirror)
	);

	lmfb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	lmfb_dp #(
		.COLS (MATRIX_COLS),
		.ROWS (MATRIX_ROWS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.mirror   (mirror),
		.cmd      (cmd),
		.req      (req_word),
		.sts      (sts),
		.wr_valid (wr_valid),
		.wr_ready (wr_ready),
		.wr_word  (wr_word)
	);

endmodule
